>>> src/urfi_pkg.sv
// Package for the UART register / FIFO interface.
// Holds action and register codes, status and control bit positions and the
// FIFO control struct. No dependencies.
`timescale 1ns / 1ps

package urfi_pkg;

   // Byte width of every data path in the block
   localparam int BYTE_W = 8;

   // Transaction action codes
   typedef enum logic [1:0] {
      ACT_BUS_READ  = 2'd0,
      ACT_BUS_WRITE = 2'd1,
      ACT_LINE_RX   = 2'd2,
      ACT_LINE_TX   = 2'd3
   } action_type;

   // Word register indexes
   typedef enum logic [1:0] {
      REG_RX_DATA = 2'd0,
      REG_TX_DATA = 2'd1,
      REG_STATUS  = 2'd2,
      REG_CONTROL = 2'd3
   } reg_index_type;

   // Status register bits
   localparam logic [BYTE_W-1:0] ST_RX_VALID = 8'h01;
   localparam logic [BYTE_W-1:0] ST_RX_FULL  = 8'h02;
   localparam logic [BYTE_W-1:0] ST_TX_EMPTY = 8'h04;
   localparam logic [BYTE_W-1:0] ST_TX_FULL  = 8'h08;

   // Control register bit positions
   localparam int CT_CLR_TX_BIT = 0;
   localparam int CT_CLR_RX_BIT = 1;
   localparam int CT_IRQ_EN_BIT = 4;

   // Per-cycle command shared by every cell of one FIFO
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } fifo_ctrl_type;

endpackage

>>> src/urfi_cell.sv
// One storage cell of the shifting FIFO chain.
// Depends on urfi_pkg for the control struct and byte width.
`timescale 1ns / 1ps

module urfi_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  urfi_pkg::fifo_ctrl_type    ctrl,
   input  logic [urfi_pkg::BYTE_W-1:0] push_data,
   input  logic                       left_valid,
   input  logic                       right_valid,
   input  logic [urfi_pkg::BYTE_W-1:0] right_data,
   output logic                       valid,
   output logic                       valid_next,
   output logic [urfi_pkg::BYTE_W-1:0] data
);
   import urfi_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] data_ff, data_in;

   // Clear empties, pop shifts towards the head, push fills the first free cell
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.pop) begin
         valid_in = right_valid;
         data_in  = right_data;
      end else if (ctrl.push && !valid_ff && left_valid) begin
         valid_in = 1'b1;
         data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid      = valid_ff;
   assign valid_next = valid_in;
   assign data       = data_ff;

endmodule

>>> src/urfi_fifo.sv
// Byte FIFO built as a row of urfi_cell stages; the head sits in cell 0.
// Depends on urfi_pkg and urfi_cell.
`timescale 1ns / 1ps

module urfi_fifo #(
   parameter int DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  urfi_pkg::fifo_ctrl_type     ctrl,
   input  logic [urfi_pkg::BYTE_W-1:0] push_data,
   output logic [urfi_pkg::BYTE_W-1:0] head_data,
   output logic                        not_empty,
   output logic                        full,
   output logic                        empty_next
);
   import urfi_pkg::*;

   logic [DEPTH-1:0]  cell_valid;
   logic [DEPTH-1:0]  cell_valid_next;
   logic [BYTE_W-1:0] cell_data [DEPTH];

   // Each cell sees the valid of its left neighbour and the contents of its right one
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic              left_v;
      logic              right_v;
      logic [BYTE_W-1:0] right_d;

      if (i == 0) begin : g_head
         assign left_v = 1'b1;
      end else begin : g_body
         assign left_v = cell_valid[i-1];
      end

      if (i == DEPTH-1) begin : g_tail
         assign right_v = 1'b0;
         assign right_d = '0;
      end else begin : g_mid
         assign right_v = cell_valid[i+1];
         assign right_d = cell_data[i+1];
      end

      urfi_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .push_data   (push_data),
         .left_valid  (left_v),
         .right_valid (right_v),
         .right_data  (right_d),
         .valid       (cell_valid[i]),
         .valid_next  (cell_valid_next[i]),
         .data        (cell_data[i])
      );
   end

   assign head_data  = cell_data[0];
   assign not_empty  = cell_valid[0];
   assign full       = cell_valid[DEPTH-1];
   assign empty_next = !cell_valid_next[0];

endmodule

>>> src/uart_register_fifo_interface_unit.sv
// Top level of the UART register / FIFO interface.
// Depends on urfi_pkg and urfi_fifo.
`timescale 1ns / 1ps

// Register side of a small UART with FIFO_DEPTH-byte receive and transmit
// FIFOs. Each request transaction is a bus read, a bus write, a byte from
// the line or the line taking the next byte; each gives exactly one response
// transaction. The response to a taken request is held in an output register
// from the next cycle on; a new request is taken in the same cycle the
// previous response is taken, so the block sustains one transaction per clock
// while the receiver holds rsp_ready high. Each FIFO is a chain of cells that
// shifts towards the head on a pop and fills its first free cell on a push.
// No clearing pass is needed after reset.
module uart_register_fifo_interface_unit #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [1:0] req_reg_index,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_line_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic [7:0] rsp_line_tx_byte,
   output logic       rsp_line_tx_valid,
   output logic       rsp_rx_dropped,
   output logic       rsp_interrupt_pending
);
   import urfi_pkg::*;

   logic              accept;
   logic              is_read, is_write;
   logic              rx_pop_req, tx_push_req, ctrl_wr, rx_push_req, tx_pop_req, status_rd;
   fifo_ctrl_type     rx_ctrl, tx_ctrl;
   logic [BYTE_W-1:0] rx_head, tx_head;
   logic              rx_not_empty, rx_full, rx_empty_next;
   logic              tx_not_empty, tx_full, tx_empty_next;

   logic              irq_enable_ff, irq_enable_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] read_data_ff, read_data_in;
   logic [BYTE_W-1:0] tx_byte_ff, tx_byte_in;
   logic              tx_valid_ff, tx_valid_in;
   logic              dropped_ff, dropped_in;
   logic              irq_ff, irq_in;

   // Handshake: the output register frees itself when its response is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Action decode
   assign is_read     = (req_action == ACT_BUS_READ);
   assign is_write    = (req_action == ACT_BUS_WRITE);
   assign rx_pop_req  = is_read && (req_reg_index == REG_RX_DATA);
   assign status_rd   = is_read && (req_reg_index == REG_STATUS);
   assign tx_push_req = is_write && (req_reg_index == REG_TX_DATA);
   assign ctrl_wr     = is_write && (req_reg_index == REG_CONTROL);
   assign rx_push_req = (req_action == ACT_LINE_RX);
   assign tx_pop_req  = (req_action == ACT_LINE_TX);

   // FIFO commands, only on an accepted transaction
   always_comb begin
      rx_ctrl.push  = accept && rx_push_req;
      rx_ctrl.pop   = accept && rx_pop_req;
      rx_ctrl.clear = accept && ctrl_wr && req_write_data[CT_CLR_RX_BIT];
      tx_ctrl.push  = accept && tx_push_req;
      tx_ctrl.pop   = accept && tx_pop_req;
      tx_ctrl.clear = accept && ctrl_wr && req_write_data[CT_CLR_TX_BIT];
   end

   urfi_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (rx_ctrl),
      .push_data  (req_line_byte),
      .head_data  (rx_head),
      .not_empty  (rx_not_empty),
      .full       (rx_full),
      .empty_next (rx_empty_next)
   );

   urfi_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (tx_ctrl),
      .push_data  (req_write_data),
      .head_data  (tx_head),
      .not_empty  (tx_not_empty),
      .full       (tx_full),
      .empty_next (tx_empty_next)
   );

   // Response and interrupt enable next values
   always_comb begin
      irq_enable_in = irq_enable_ff;
      rsp_valid_in  = rsp_valid_ff;
      read_data_in  = read_data_ff;
      tx_byte_in    = tx_byte_ff;
      tx_valid_in   = tx_valid_ff;
      dropped_in    = dropped_ff;
      irq_in        = irq_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         if (ctrl_wr) begin
            irq_enable_in = req_write_data[CT_IRQ_EN_BIT];
         end
         rsp_valid_in = 1'b1;
         read_data_in = '0;
         if (rx_pop_req && rx_not_empty) begin
            read_data_in = rx_head;
         end else if (status_rd) begin
            read_data_in = (rx_not_empty ? ST_RX_VALID : '0)
                         | (rx_full      ? ST_RX_FULL  : '0)
                         | (!tx_not_empty ? ST_TX_EMPTY : '0)
                         | (tx_full      ? ST_TX_FULL  : '0);
         end
         tx_valid_in = tx_pop_req && tx_not_empty;
         tx_byte_in  = tx_valid_in ? tx_head : '0;
         dropped_in  = rx_push_req && rx_full;
         irq_in      = irq_enable_in && (!rx_empty_next || tx_empty_next);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         irq_enable_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         irq_enable_ff <= irq_enable_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      read_data_ff <= read_data_in;
      tx_byte_ff   <= tx_byte_in;
      tx_valid_ff  <= tx_valid_in;
      dropped_ff   <= dropped_in;
      irq_ff       <= irq_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_data         = read_data_ff;
   assign rsp_line_tx_byte      = tx_byte_ff;
   assign rsp_line_tx_valid     = tx_valid_ff;
   assign rsp_rx_dropped        = dropped_ff;
   assign rsp_interrupt_pending = irq_ff;

endmodule

>>> verif/uart_register_fifo_interface_unit_tb.sv
// Self-checking testbench for uart_register_fifo_interface_unit: a directed table
// followed by random bus and line transactions, each checked against an in-bench model
// or a typed table response. Depends on urfi_pkg and the RTL under src/.
`timescale 1ns / 1ps

module uart_register_fifo_interface_unit_tb;
   import urfi_pkg::*;

   localparam int FIFO_DEPTH   = 16;
   localparam int RANDOM_ITEMS = 1000;
   localparam int DRAIN_CYCLES = 16;

   // One response transaction, field for field
   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic       dropped;
      logic       irq;
   } uart_rsp_type;

   // One row of the directed table; reps > 1 steps the data bytes by one each time
   typedef struct packed {
      action_type    act;
      reg_index_type ri;
      logic [7:0]    wd;
      logic [7:0]    lb;
      logic [4:0]    reps;
      logic          typed;
      uart_rsp_type  rsp;
   } stim_row_type;

   localparam uart_rsp_type IDLE_RSP = '0;
   localparam uart_rsp_type IRQ_RSP  = '{8'h00, 8'h00, 1'b0, 1'b0, 1'b1};

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   action_type    req_action;
   reg_index_type req_reg_index;
   logic [7:0]    req_write_data;
   logic [7:0]    req_line_byte;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [7:0]    rsp_read_data;
   logic [7:0]    rsp_line_tx_byte;
   logic          rsp_line_tx_valid;
   logic          rsp_rx_dropped;
   logic          rsp_interrupt_pending;

   // Typed expectation travelling with the current request, if any
   logic          row_typed;
   uart_rsp_type  row_rsp;

   // Model state: the two FIFOs as queues plus the interrupt enable
   logic [7:0]    rx_bytes[$];
   logic [7:0]    tx_bytes[$];
   logic          irq_en = 1'b0;

   uart_rsp_type  pending_rsp[$];
   int            fail_count     = 0;
   int            accepted_count = 0;
   int            burst_left     = 0;

   uart_register_fifo_interface_unit #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_reg_index        (req_reg_index),
      .req_write_data       (req_write_data),
      .req_line_byte        (req_line_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_read_data        (rsp_read_data),
      .rsp_line_tx_byte     (rsp_line_tx_byte),
      .rsp_line_tx_valid    (rsp_line_tx_valid),
      .rsp_rx_dropped       (rsp_rx_dropped),
      .rsp_interrupt_pending(rsp_interrupt_pending)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Applies one transaction to the model and returns the response it gives
   function automatic uart_rsp_type uart_access_result(input action_type act,
                                                       input reg_index_type ri,
                                                       input logic [7:0] wd,
                                                       input logic [7:0] lb);
      uart_rsp_type r;
      r = '0;
      case (act)
         ACT_BUS_READ: begin
            if (ri == REG_RX_DATA) begin
               if (rx_bytes.size() != 0) r.read_data = rx_bytes.pop_front();
            end else if (ri == REG_STATUS) begin
               if (rx_bytes.size() != 0) r.read_data |= ST_RX_VALID;
               if (rx_bytes.size() >= FIFO_DEPTH) r.read_data |= ST_RX_FULL;
               if (tx_bytes.size() == 0) r.read_data |= ST_TX_EMPTY;
               if (tx_bytes.size() >= FIFO_DEPTH) r.read_data |= ST_TX_FULL;
            end
         end
         ACT_BUS_WRITE: begin
            if (ri == REG_TX_DATA) begin
               if (tx_bytes.size() < FIFO_DEPTH) tx_bytes.push_back(wd);
            end else if (ri == REG_CONTROL) begin
               if (wd[CT_CLR_TX_BIT]) tx_bytes.delete();
               if (wd[CT_CLR_RX_BIT]) rx_bytes.delete();
               irq_en = wd[CT_IRQ_EN_BIT];
            end
         end
         ACT_LINE_RX: begin
            if (rx_bytes.size() < FIFO_DEPTH) rx_bytes.push_back(lb);
            else r.dropped = 1'b1;
         end
         default: begin
            if (tx_bytes.size() != 0) begin
               r.tx_byte  = tx_bytes.pop_front();
               r.tx_valid = 1'b1;
            end
         end
      endcase
      r.irq = irq_en && (rx_bytes.size() != 0 || tx_bytes.size() == 0);
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%02h, got 0x%02h", field, want, got);
         fail_count++;
      end
   endtask

   // Response check against the oldest expectation, then record any accepted request
   always @(posedge clock) begin : scoreboard
      uart_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("response transaction with nothing pending");
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               compare_field("read_data", want.read_data, rsp_read_data);
               compare_field("line_tx_byte", want.tx_byte, rsp_line_tx_byte);
               compare_field("line_tx_valid", 8'(want.tx_valid), 8'(rsp_line_tx_valid));
               compare_field("rx_dropped", 8'(want.dropped), 8'(rsp_rx_dropped));
               compare_field("interrupt_pending", 8'(want.irq),
                             8'(rsp_interrupt_pending));
            end
         end
         if (req_valid && req_ready) begin
            want = uart_access_result(req_action, req_reg_index, req_write_data,
                                      req_line_byte);
            if (row_typed) want = row_rsp;
            pending_rsp.push_back(want);
            accepted_count++;
         end
      end
   end

   // Offers one request transaction, in bursts with random gaps between them
   task automatic offer(input action_type act, input reg_index_type ri,
                        input logic [7:0] wd, input logic [7:0] lb,
                        input logic typed, input uart_rsp_type rsp);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 40);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_action     <= act;
      req_reg_index  <= ri;
      req_write_data <= wd;
      req_line_byte  <= lb;
      row_typed      <= typed;
      row_rsp        <= rsp;
      do @(posedge clock); while (!req_ready);
   endtask

   // Receiver: changing stall styles, plus two long hold-offs to back up the input
   initial begin : receiver
      int         phase_left;
      int         style;
      int         holdoffs;
      logic [7:0] pattern;
      phase_left = 0;
      style      = 0;
      holdoffs   = 0;
      pattern    = 8'b1011_0110;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoffs < 2 && accepted_count >= 250 + 450 * holdoffs) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            holdoffs++;
         end else begin
            if (phase_left == 0) begin
               style      = $urandom_range(3);
               phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            case (style)
               0: rsp_ready <= 1'b1;
               1: begin
                  rsp_ready <= pattern[0];
                  pattern = {pattern[0], pattern[7:1]};
               end
               2: rsp_ready <= 1'($urandom_range(1));
               default: rsp_ready <= ($urandom_range(4) == 0);
            endcase
         end
      end
   end

   // Stimulus: directed table, then random transactions, then drain and verdict
   initial begin : stimulus
      stim_row_type  directed [23];
      action_type    act;
      reg_index_type ri;
      int            mode;
      int            pick;
      int            op;

      directed = '{
         // status after reset: only tx empty
         '{ACT_BUS_READ,  REG_STATUS,  8'h00, 8'h00, 5'd1,  1'b1, '{8'h04, 8'h00, 1'b0, 1'b0, 1'b0}},
         // empty rx data reads as zero
         '{ACT_BUS_READ,  REG_RX_DATA, 8'h00, 8'h00, 5'd1,  1'b1, IDLE_RSP},
         // line pulls from an empty tx FIFO
         '{ACT_LINE_TX,   REG_STATUS,  8'hFF, 8'hFF, 5'd1,  1'b1, IDLE_RSP},
         // write-only registers read as zero
         '{ACT_BUS_READ,  REG_TX_DATA, 8'h00, 8'h00, 5'd1,  1'b1, IDLE_RSP},
         '{ACT_BUS_READ,  REG_CONTROL, 8'h00, 8'h00, 5'd1,  1'b1, IDLE_RSP},
         // irq enable with tx empty raises the interrupt
         '{ACT_BUS_WRITE, REG_CONTROL, 8'h10, 8'h00, 5'd1,  1'b1, IRQ_RSP},
         // writes to read-only registers are ignored
         '{ACT_BUS_WRITE, REG_RX_DATA, 8'hFF, 8'h00, 5'd1,  1'b1, IRQ_RSP},
         '{ACT_BUS_WRITE, REG_STATUS,  8'hFF, 8'h00, 5'd1,  1'b1, IRQ_RSP},
         '{ACT_LINE_RX,   REG_CONTROL, 8'h00, 8'hFF, 5'd1,  1'b0, IDLE_RSP},
         '{ACT_LINE_RX,   REG_TX_DATA, 8'hFF, 8'h00, 5'd1,  1'b0, IDLE_RSP},
         '{ACT_BUS_READ,  REG_RX_DATA, 8'h00, 8'h00, 5'd1,  1'b0, IDLE_RSP},
         '{ACT_BUS_READ,  REG_RX_DATA, 8'h00, 8'h00, 5'd1,  1'b0, IDLE_RSP},
         '{ACT_BUS_WRITE, REG_TX_DATA, 8'hA5, 8'h00, 5'd1,  1'b0, IDLE_RSP},
         '{ACT_LINE_TX,   REG_RX_DATA, 8'h00, 8'h00, 5'd1,  1'b0, IDLE_RSP},
         // clear both FIFOs with every other bit set, interrupt off
         '{ACT_BUS_WRITE, REG_CONTROL, 8'hEF, 8'h00, 5'd1,  1'b1, IDLE_RSP},
         // fill rx, then one more is dropped and flagged
         '{ACT_LINE_RX,   REG_RX_DATA, 8'h00, 8'h80, 5'd16, 1'b0, IDLE_RSP},
         '{ACT_LINE_RX,   REG_RX_DATA, 8'h00, 8'h55, 5'd1,  1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 1'b0}},
         // fill tx, the last write is dropped silently
         '{ACT_BUS_WRITE, REG_TX_DATA, 8'h01, 8'h00, 5'd17, 1'b0, IDLE_RSP},
         // rx valid, rx full and tx full
         '{ACT_BUS_READ,  REG_STATUS,  8'h00, 8'h00, 5'd1,  1'b1, '{8'h0B, 8'h00, 1'b0, 1'b0, 1'b0}},
         '{ACT_BUS_WRITE, REG_CONTROL, 8'h12, 8'h00, 5'd1,  1'b0, IDLE_RSP},
         '{ACT_LINE_TX,   REG_CONTROL, 8'h00, 8'h00, 5'd16, 1'b0, IDLE_RSP},
         '{ACT_LINE_TX,   REG_CONTROL, 8'h00, 8'h00, 5'd1,  1'b0, IDLE_RSP},
         '{ACT_BUS_WRITE, REG_CONTROL, 8'h01, 8'h00, 5'd1,  1'b0, IDLE_RSP}
      };

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_action     = ACT_BUS_READ;
      req_reg_index  = REG_RX_DATA;
      req_write_data = 8'h00;
      req_line_byte  = 8'h00;
      row_typed      = 1'b0;
      row_rsp        = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[n]) begin
         for (int k = 0; k < int'(directed[n].reps); k++) begin
            offer(directed[n].act, directed[n].ri, directed[n].wd + 8'(k),
                  directed[n].lb + 8'(k), directed[n].typed, directed[n].rsp);
         end
      end

      // Random part: modes favour one operation so the FIFOs reach full and empty
      mode = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 48 == 0) mode = $urandom_range(5);
         pick = $urandom_range(99);
         act  = action_type'($urandom_range(3));
         ri   = reg_index_type'($urandom_range(3));
         if (pick < 2) begin
            act = ACT_BUS_WRITE;
            ri  = REG_CONTROL;
         end else if (pick >= 10) begin
            op = (mode != 0 && $urandom_range(9) < 6) ? mode - 1 : $urandom_range(4);
            case (op)
               0: act = ACT_LINE_RX;
               1: begin
                  act = ACT_BUS_READ;
                  ri  = REG_RX_DATA;
               end
               2: begin
                  act = ACT_BUS_WRITE;
                  ri  = REG_TX_DATA;
               end
               3: act = ACT_LINE_TX;
               default: begin
                  act = ACT_BUS_READ;
                  ri  = REG_STATUS;
               end
            endcase
         end
         offer(act, ri, 8'($urandom), 8'($urandom), 1'b0, IDLE_RSP);
      end

      // One edge first so the last accepted request is already queued
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("uart_register_fifo_interface_unit_tb OK");
      end else begin
         $display("uart_register_fifo_interface_unit_tb NOT OK");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("uart_register_fifo_interface_unit_tb NOT OK");
      $finish;
   end

endmodule

>>> filelist.f
src/urfi_pkg.sv
src/urfi_cell.sv
src/urfi_fifo.sv
src/uart_register_fifo_interface_unit.sv
verif/uart_register_fifo_interface_unit_tb.sv
